@@ design/sm3_pkg.sv @@
package sm3_pkg;

  localparam int WordWidth = 32;
  localparam int NumRounds = 64;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } sm3_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sm3_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_COMP,
    ST_FINAL,
    ST_EMIT
  } sm3_state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic take_byte;
    logic pad_start;
    logic len_fill;
    logic round_start;
    logic round_step;
    logic round_done;
    logic reset_state;
  } sm3_cmd_t;

  typedef struct packed {
    logic [5:0] fill_count;
    logic [5:0] round;
  } sm3_status_t;

  localparam logic [255:0] InitVec = {
    32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
    32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
  };
  localparam logic [31:0] TjLow  = 32'h79cc4519;
  localparam logic [31:0] TjHigh = 32'h7a879d8a;
  localparam logic [7:0]  PadByte = 8'h80;

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] t;
    t = {x, x} << n;
    return t[63:32];
  endfunction

  function automatic logic [31:0] perm0(input logic [31:0] x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic logic [31:0] perm1(input logic [31:0] x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

endpackage

@@ design/sm3_datapath.sv @@
module sm3_datapath
  import sm3_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  sm3_cmd_t    cmd,
  input  logic [7:0]  data_byte,
  input  logic [2:0]  out_sel,
  output sm3_status_t status,
  output logic [31:0] digest_word
);

  // The 64-byte block is held as sixteen big-endian words.
  logic [31:0] blk_word [16];
  logic [5:0]  fill_count;
  logic [60:0] total_bytes;
  logic [31:0] chain_value [8];
  logic [31:0] reg_a, reg_b, reg_c, reg_d, reg_e, reg_f, reg_g, reg_h;
  logic [31:0] w [16];
  logic [5:0]  round;

  logic [31:0] w_new, a12, ss1, ss2, tj, ff, gg, tt1, tt2;
  logic [31:0] a_next, c_next, e_next, g_next;
  logic [63:0] bit_len;
  logic [4:0]  lane_lsb;

  assign bit_len = {total_bytes, 3'b000};
  assign lane_lsb = {~fill_count[1:0], 3'b000};
  assign status.fill_count = fill_count;
  assign status.round = round;
  assign digest_word = chain_value[out_sel];

  // Sixteen-word window of the message schedule; w[0] is W[j], w[4] is W[j+4].
  always_comb begin
    w_new = perm1(w[0] ^ w[7] ^ rotl(w[13], 5'd15)) ^ rotl(w[3], 5'd7) ^ w[10];
    a12 = rotl(reg_a, 5'd12);
    tj = (round < 6'd16) ? TjLow : TjHigh;
    ss1 = rotl(a12 + reg_e + rotl(tj, round[4:0]), 5'd7);
    ss2 = ss1 ^ a12;
    if (round < 6'd16) begin
      ff = reg_a ^ reg_b ^ reg_c;
      gg = reg_e ^ reg_f ^ reg_g;
    end else begin
      ff = (reg_a & reg_b) | (reg_a & reg_c) | (reg_b & reg_c);
      gg = (reg_e & reg_f) | (~reg_e & reg_g);
    end
    tt1 = ff + reg_d + ss2 + (w[0] ^ w[4]);
    tt2 = gg + reg_h + ss1 + w[0];
    a_next = tt1;
    c_next = rotl(reg_b, 5'd9);
    e_next = perm0(tt2);
    g_next = rotl(reg_f, 5'd19);
  end

  // Block buffer: byte writes, pad writes, length writes.
  always_ff @(posedge clk) begin
    if (cmd.take_byte) begin
      blk_word[fill_count[5:2]][lane_lsb +: 8] <= data_byte;
    end else if (cmd.pad_start) begin
      for (int i = 0; i < 16; i++) begin
        for (int l = 0; l < 4; l++) begin
          if (6'(4*i+l) == fill_count) blk_word[i][8*(3-l) +: 8] <= PadByte;
          else if (6'(4*i+l) > fill_count) blk_word[i][8*(3-l) +: 8] <= 8'h00;
        end
      end
    end else if (cmd.len_fill) begin
      if (fill_count >= 6'd56) begin
        for (int i = 0; i < 14; i++) blk_word[i] <= '0;
      end
      blk_word[14] <= bit_len[63:32];
      blk_word[15] <= bit_len[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.reset_state) begin
      fill_count <= '0;
      total_bytes <= '0;
      for (int k = 0; k < 8; k++) chain_value[k] <= InitVec[32*(7-k) +: 32];
    end else begin
      if (cmd.take_byte) begin
        fill_count <= fill_count + 6'd1;
        total_bytes <= total_bytes + 61'd1;
      end
      // The final round's results are folded in directly.
      if (cmd.round_done) begin
        chain_value[0] <= chain_value[0] ^ a_next;
        chain_value[1] <= chain_value[1] ^ reg_a;
        chain_value[2] <= chain_value[2] ^ c_next;
        chain_value[3] <= chain_value[3] ^ reg_c;
        chain_value[4] <= chain_value[4] ^ e_next;
        chain_value[5] <= chain_value[5] ^ reg_e;
        chain_value[6] <= chain_value[6] ^ g_next;
        chain_value[7] <= chain_value[7] ^ reg_g;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.round_start) begin
      round <= '0;
      reg_a <= chain_value[0]; reg_b <= chain_value[1];
      reg_c <= chain_value[2]; reg_d <= chain_value[3];
      reg_e <= chain_value[4]; reg_f <= chain_value[5];
      reg_g <= chain_value[6]; reg_h <= chain_value[7];
      for (int k = 0; k < 16; k++) w[k] <= blk_word[k];
    end else if (cmd.round_step) begin
      round <= round + 6'd1;
      reg_d <= reg_c;
      reg_c <= c_next;
      reg_b <= reg_a;
      reg_a <= a_next;
      reg_h <= reg_g;
      reg_g <= g_next;
      reg_f <= reg_e;
      reg_e <= e_next;
      for (int k = 0; k < 15; k++) w[k] <= w[k+1];
      w[15] <= w_new;
    end
  end

endmodule

@@ design/sm3_control.sv @@
module sm3_control
  import sm3_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  sm3_in_t     in_item,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        out_stall,
  output logic        out_valid,
  output logic [2:0]  out_sel,
  input  sm3_status_t status,
  output sm3_cmd_t    cmd
);

  sm3_state_t state, state_next;
  logic       final_pend;   // the message ends with the current transaction
  logic       padded;       // padding has been written for this message
  logic       second;       // a length-only block is still owed
  logic [2:0] word_cnt;
  logic       accept, comp_end, emit_end;

  assign accept = in_valid && !in_stall;
  assign comp_end = (state == ST_COMP) && (status.round == 6'(NumRounds - 1));
  assign emit_end = (state == ST_EMIT) && !out_stall && word_cnt == 3'd7;
  assign out_sel = word_cnt;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_item.has_byte && status.fill_count == 6'd63) state_next = ST_LOAD;
          else if (in_item.last) state_next = ST_PAD;
        end
      end
      ST_PAD: begin
        if (status.fill_count >= 6'd56) state_next = ST_LOAD;
        else state_next = ST_FINAL;
      end
      ST_FINAL: state_next = ST_LOAD;
      ST_LOAD:  state_next = ST_COMP;
      ST_COMP: begin
        if (comp_end) begin
          if (second) state_next = ST_FINAL;
          else if (padded) state_next = ST_EMIT;
          else if (final_pend) state_next = ST_PAD;
          else state_next = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (emit_end) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = (state != ST_IDLE);
    out_valid = (state == ST_EMIT);
    unique case (state)
      ST_IDLE:  cmd.take_byte = accept && in_item.has_byte;
      ST_PAD:   cmd.pad_start = 1'b1;
      ST_FINAL: cmd.len_fill = 1'b1;
      ST_LOAD:  cmd.round_start = 1'b1;
      ST_COMP: begin
        cmd.round_step = 1'b1;
        cmd.round_done = comp_end;
      end
      ST_EMIT: cmd.reset_state = emit_end;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      final_pend <= 1'b0;
      padded <= 1'b0;
      second <= 1'b0;
      word_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && accept) final_pend <= in_item.last;
      if (state == ST_PAD) padded <= 1'b1;
      else if (emit_end) padded <= 1'b0;
      if (state == ST_PAD) second <= (status.fill_count >= 6'd56);
      if (state == ST_FINAL) second <= 1'b0;
      if (state == ST_EMIT && !out_stall) word_cnt <= word_cnt + 3'd1;
    end
  end

endmodule

@@ design/sm3_hash_engine.sv @@
// SM3 hash engine taking one message byte per transaction. A byte that does
// not fill the 64-byte block is taken without a stall. A byte that fills it
// starts a compression of 64 rounds, one round per cycle in a single shared
// round unit with a rolling sixteen-word schedule, after a load state, and
// the input stalls until that compression ends. A transaction with last set
// pads, loads the length and compresses once or twice (twice when fewer than
// nine bytes remain free), after the compression of a block that its own byte
// filled, then delivers the digest as eight 32-bit words, most significant
// first, and returns to the initial vector.
module sm3_hash_engine
  import sm3_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  sm3_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output sm3_out_t out_data
);

  sm3_cmd_t    cmd;
  sm3_status_t status;
  logic [2:0]  out_sel;
  logic [31:0] digest_word;

  sm3_control u_ctrl (
    .clk(clk), .rst(rst), .in_item(in_data), .in_valid(in_valid),
    .in_stall(in_stall), .out_stall(out_stall), .out_valid(out_valid),
    .out_sel(out_sel), .status(status), .cmd(cmd)
  );

  sm3_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .data_byte(in_data.data_byte),
    .out_sel(out_sel), .status(status), .digest_word(digest_word)
  );

  assign out_data.digest_word = digest_word;
  assign out_data.word_index = out_sel;
  assign out_data.last_word = (out_sel == 3'd7);

endmodule

@@ verif/sm3_hash_engine_tb.sv @@
`timescale 1ns / 100ps

module sm3_hash_engine_tb;
  import sm3_pkg::*;

  localparam int IdleLimit = 3000;
  localparam int LongHold = 400;

  class sm3_scoreboard;
    bit [31:0] chain[8];
    bit [7:0] blk[64];
    int unsigned fill;
    bit [60:0] total_bytes;
    sm3_out_t digest_q[$];
    int errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      for (int k = 0; k < 8; k++) chain[k] = InitVec[255 - 32 * k -: 32];
      for (int k = 0; k < 64; k++) blk[k] = 8'h00;
      fill = 0;
      total_bytes = '0;
    endfunction

    function bit [31:0] rol(bit [31:0] x, int unsigned n);
      n = n % 32;
      if (n == 0) return x;
      return (x << n) | (x >> (32 - n));
    endfunction

    function bit [31:0] p0(bit [31:0] x);
      return x ^ rol(x, 9) ^ rol(x, 17);
    endfunction

    function bit [31:0] p1(bit [31:0] x);
      return x ^ rol(x, 15) ^ rol(x, 23);
    endfunction

    function void compress();
      bit [31:0] w[68];
      bit [31:0] wp[64];
      bit [31:0] a, b, c, d, e, f, g, h;
      bit [31:0] ss1, ss2, tt1, tt2, tj, ff, gg;
      for (int j = 0; j < 16; j++)
        w[j] = {blk[4 * j], blk[4 * j + 1], blk[4 * j + 2], blk[4 * j + 3]};
      for (int j = 16; j < 68; j++)
        w[j] = p1(w[j - 16] ^ w[j - 9] ^ rol(w[j - 3], 15)) ^ rol(w[j - 13], 7) ^ w[j - 6];
      for (int j = 0; j < 64; j++) wp[j] = w[j] ^ w[j + 4];
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
      e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
      for (int j = 0; j < 64; j++) begin
        tj = (j < 16) ? TjLow : TjHigh;
        ss1 = rol(rol(a, 12) + e + rol(tj, j), 7);
        ss2 = ss1 ^ rol(a, 12);
        if (j < 16) begin
          ff = a ^ b ^ c;
          gg = e ^ f ^ g;
        end else begin
          ff = (a & b) | (a & c) | (b & c);
          gg = (e & f) | (~e & g);
        end
        tt1 = ff + d + ss2 + wp[j];
        tt2 = gg + h + ss1 + w[j];
        d = c;
        c = rol(b, 9);
        b = a;
        a = tt1;
        h = g;
        g = rol(f, 19);
        f = e;
        e = p0(tt2);
      end
      chain[0] ^= a; chain[1] ^= b; chain[2] ^= c; chain[3] ^= d;
      chain[4] ^= e; chain[5] ^= f; chain[6] ^= g; chain[7] ^= h;
    endfunction

    function void note_input(sm3_in_t x);
      bit [63:0] bits;
      int unsigned p;
      sm3_out_t d;
      if (x.has_byte) begin
        blk[fill] = x.data_byte;
        total_bytes = total_bytes + 1;
        fill = (fill + 1) % 64;
        if (fill == 0) compress();
      end
      if (!x.last) return;
      p = fill;
      blk[p] = PadByte;
      for (int k = p + 1; k < 64; k++) blk[k] = 8'h00;
      // Not enough room for the length: flush this block and pad a fresh one.
      if (p >= 56) begin
        compress();
        for (int k = 0; k < 64; k++) blk[k] = 8'h00;
      end
      bits = {total_bytes, 3'b000};
      for (int k = 0; k < 8; k++) blk[56 + k] = bits[63 - 8 * k -: 8];
      compress();
      for (int k = 0; k < 8; k++) begin
        d.digest_word = chain[k];
        d.word_index = k[2:0];
        d.last_word = (k == 7);
        digest_q.push_back(d);
      end
      restart();
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(sm3_out_t got);
      sm3_out_t exp_d;
      if (digest_q.size() == 0) begin
        report($sformatf("unexpected digest word %h", got.digest_word));
        return;
      end
      exp_d = digest_q.pop_front();
      if (got.digest_word !== exp_d.digest_word)
        report($sformatf("digest_word %h, want %h", got.digest_word, exp_d.digest_word));
      if (got.word_index !== exp_d.word_index)
        report($sformatf("word_index %0d, want %0d", got.word_index, exp_d.word_index));
      if (got.last_word !== exp_d.last_word)
        report($sformatf("last_word %b, want %b", got.last_word, exp_d.last_word));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  sm3_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  sm3_out_t out_data;

  sm3_scoreboard sb = new();
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  int items_sent = 0;

  sm3_hash_engine uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Receiver: checks results and stalls in random bursts.
  initial begin
    int burst;
    burst = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) sb.check_result(out_data);
      if (hold_req) begin
        hold_req = 1'b0;
        burst = LongHold;
      end else if (burst == 0 && !quiet && $urandom_range(0, 6) == 0) begin
        burst = $urandom_range(1, 19);
      end
      if (burst > 0) begin
        burst--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
      if (idle >= IdleLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task send(input logic [7:0] b, input bit has, input bit fin);
    sm3_in_t x;
    x.data_byte = b;
    x.has_byte = has;
    x.last = fin;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= x;
    do @(posedge clk); while (!(in_valid && !in_stall));
    sb.note_input(x);
    items_sent++;
  endtask

  // A message of len bytes; the final byte rides on the last transaction when
  // with_byte is set, otherwise a byteless last transaction closes it.
  task send_message(input int len, input bit with_byte);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 15) == 0) send($urandom_range(0, 255), 1'b0, 1'b0);
      send($urandom_range(0, 255), 1'b1, with_byte && i == len - 1);
    end
    if (!with_byte || len == 0) send($urandom_range(0, 255), 1'b0, 1'b1);
  endtask

  task wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.digest_q.size() != 0);
  endtask

  initial begin
    int msgs;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty message, "abc", single extreme bytes, ignored items.
    send(8'h00, 1'b0, 1'b1);
    send(8'h61, 1'b1, 1'b0);
    send(8'h62, 1'b1, 1'b0);
    send(8'h63, 1'b1, 1'b1);
    send(8'hff, 1'b0, 1'b0);
    send(8'h00, 1'b0, 1'b0);
    send(8'hff, 1'b1, 1'b1);
    send(8'h00, 1'b1, 1'b0);
    send(8'haa, 1'b0, 1'b1);
    send(8'h55, 1'b1, 1'b1);

    // Padding boundaries: last fit, first overflow, exactly one full block.
    send_message(55, 1'b0);
    send_message(56, 1'b1);
    send_message(64, 1'b0);

    // Hold the output long enough that the engine backs up onto its input.
    hold_req = 1'b1;
    for (int i = 0; i < 3; i++) send_message($urandom_range(1, 6), $urandom_range(0, 1));
    wait_drained();

    msgs = 0;
    while (items_sent < 230) begin
      if (items_sent > 200) quiet = 1'b1;
      if ($urandom_range(0, 7) == 0) send_message($urandom_range(40, 70), $urandom_range(0, 1));
      else send_message($urandom_range(0, 12), $urandom_range(0, 1));
      msgs++;
      if (msgs == 4) wait_drained();
    end
    in_valid <= 1'b0;

    while (sb.digest_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
